>>> src/rgbshp_pkg.sv
// Package for the streaming RGB 3x3 sharpen block: shared types, register
// indexes, reset values and the per-channel sharpen arithmetic.
// No dependencies.
package rgbshp_pkg;

  // Geometry and storage
  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned LinesKept   = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStrength    = 2'd2;

  localparam logic [11:0] FrameWidthRst  = 12'd640;
  localparam logic [11:0] FrameHeightRst = 12'd480;
  localparam logic [7:0]  StrengthRst    = 8'd48;

  // One pixel: [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] pix_t;

  // One vertical column of the window
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Control and data carried from the accept stage to the compute stage
  typedef struct packed {
    logic produce;
    logic left_e;
    logic right_e;
    logic top_e;
    logic bot_e;
    logic frame_end;
    pix_t pix;
  } s1_t;

  // Clamp the bottom row to the middle at the last row, then reflect the
  // top row onto the (already clamped) bottom at the first row.
  function automatic col_t vfix(col_t cin, logic top_e, logic bot_e);
    col_t r;
    r = cin;
    if (bot_e) begin
      r.bot = cin.mid;
    end
    if (top_e) begin
      r.top = r.bot;
    end
    return r;
  endfunction

  // n = 128*c + s*(8*c - nsum); negative gives 0, else min(n >> 7, 255)
  function automatic logic [7:0] sharpen_ch(logic [7:0] c, logic [10:0] nsum,
                                            logic [7:0] s);
    logic signed [11:0] d;
    logic signed [19:0] p;
    logic signed [20:0] n;
    logic [7:0]         res;
    d = $signed({1'b0, c, 3'b000}) - $signed({1'b0, nsum});
    p = $signed({1'b0, s}) * d;
    n = $signed({6'b0, c, 7'b0}) + 21'(p);
    if (n[20]) begin
      res = 8'd0;
    end else if (|n[19:15]) begin
      res = 8'd255;
    end else begin
      res = n[14:7];
    end
    return res;
  endfunction

endpackage

>>> src/rgb_sharpen_3x3_stream_top.sv
// Top level of the streaming RGB 3x3 sharpen block.
// Depends on rgbshp_pkg and rgbshp_ram.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid_i/in_ready_o | kind_i, red_in_i, green_in_i, blue_in_i
//  out      | out_valid_o/out_ready_i | red_out_o, green_out_o, blue_out_o,
//           |                       | frame_end_o
//  cfg      | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// One word is taken every cycle unless the compute stage stalls; a result
// follows the word completing its window via line store read, then compute.
// Throughput is set by the line store, which does one write and two reads
// per cycle. Reset loads 640 x 480, strength 48, and clears the counters;
// the line store is not cleared. A stalled output holds its register; the
// input keeps taking words until the compute stage also fills.
module rgb_sharpen_3x3_stream_top #(
  parameter int unsigned MAX_WIDTH = rgbshp_pkg::MaxWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rgbshp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rgbshp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [7:0]                       red_in_i,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic                             frame_end_o
);

  import rgbshp_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned Depth = LinesKept * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);

  function automatic logic [AW-1:0] addr_of(logic [1:0] slot, logic [CW-1:0] col);
    return AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  // Configuration registers
  logic [11:0] fw_q, fh_q;
  logic [7:0]  str_q;
  logic        cfg_geom_wr;

  // Accept-stage counters
  logic [CW-1:0] in_col_q, in_col_d;
  logic [11:0]   in_row_q, in_row_d;
  logic          in_done_q, in_done_d;
  logic [1:0]    prime_q, prime_d;
  logic [1:0]    slot_q, slot_d;
  logic [CW-1:0] out_x_q, out_x_d;
  logic [11:0]   out_y_q, out_y_d;

  logic [CW-1:0] last_col;
  logic [11:0]   last_row;
  logic          in_fire, take, is_pixel, produce, frame_end, at_end_col;
  logic [1:0]    slot_nxt, slot_mid, slot_top;
  s1_t           s1_info;

  // Compute stage
  logic          s1_valid_q, s1_valid_d, s1_adv;
  s1_t           s1_q;
  col_t          col_a_q, col_b_q, col_n;
  col_t          win_l, win_c, win_r;
  pix_t          rd_mid, rd_top, res_pix;

  // Output register
  logic          out_valid_q, out_valid_d;
  pix_t          out_pix_q;
  logic          out_fe_q;

  // ---------------------------------------------------------------------
  // Configuration writes
  assign cfg_geom_wr = cfg_we_i &&
                       (cfg_idx_i == RegFrameWidth || cfg_idx_i == RegFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FrameWidthRst;
      fh_q  <= FrameHeightRst;
      str_q <= StrengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameWidth:  fw_q  <= cfg_data_i[11:0];
        RegFrameHeight: fh_q  <= cfg_data_i[11:0];
        RegStrength:    str_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, width saturates at MAX_WIDTH
  always_comb begin
    if (fw_q == 12'd0) begin
      last_col = '0;
    end else if ({20'd0, fw_q} > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(fw_q - 12'd1);
    end
    last_row = (fh_q == 12'd0) ? 12'd0 : fh_q - 12'd1;
  end

  // ---------------------------------------------------------------------
  // Accept stage: decode the word against the frame position
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_pixel   = !in_done_q;
  // drop early flush words entirely
  assign take       = in_fire && !(kind_i && !in_done_q);
  assign at_end_col = (in_col_q == last_col);
  assign produce    = prime_q[1] || (prime_q[0] && in_col_q != '0);
  assign frame_end  = produce && out_x_q == last_col && out_y_q == last_row;

  assign slot_nxt = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
  assign slot_mid = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
  assign slot_top = (slot_mid == 2'd0) ? 2'd2 : slot_mid - 2'd1;

  always_comb begin
    s1_info.produce   = produce;
    s1_info.left_e    = (out_x_q == '0);
    s1_info.right_e   = (out_x_q == last_col);
    s1_info.top_e     = (out_y_q == 12'd0);
    s1_info.bot_e     = (out_y_q == last_row);
    s1_info.frame_end = frame_end;
    s1_info.pix       = {red_in_i, green_in_i, blue_in_i};
  end

  // Advance input and output positions
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_done_d = in_done_q;
    prime_d   = prime_q;
    slot_d    = slot_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    if (cfg_geom_wr || (take && frame_end)) begin
      in_col_d  = '0;
      in_row_d  = 12'd0;
      in_done_d = 1'b0;
      prime_d   = 2'd0;
      slot_d    = 2'd0;
      out_x_d   = '0;
      out_y_d   = 12'd0;
    end else if (take) begin
      if (at_end_col) begin
        in_col_d = '0;
        slot_d   = slot_nxt;
        if (!prime_q[1]) begin
          prime_d = prime_q + 2'd1;
        end
        if (is_pixel) begin
          if (in_row_q == last_row) begin
            in_done_d = 1'b1;
          end else begin
            in_row_d = in_row_q + 12'd1;
          end
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (produce) begin
        if (out_x_q == last_col) begin
          out_x_d = '0;
          out_y_d = out_y_q + 12'd1;
        end else begin
          out_x_d = out_x_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= 12'd0;
      in_done_q <= 1'b0;
      prime_q   <= 2'd0;
      slot_q    <= 2'd0;
      out_x_q   <= '0;
      out_y_q   <= 12'd0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_done_q <= in_done_d;
      prime_q   <= prime_d;
      slot_q    <= slot_d;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
    end
  end

  // Line store: write the current row, read the two rows above it
  rgbshp_ram #(
    .WIDTH($bits(pix_t)),
    .DEPTH(Depth)
  ) u_line_store (
    .clk_i    (clk_i),
    .we_i     (take && is_pixel),
    .waddr_i  (addr_of(slot_q, in_col_q)),
    .wdata_i  (s1_info.pix),
    .re_i     (take),
    .raddr_a_i(addr_of(slot_mid, in_col_q)),
    .raddr_b_i(addr_of(slot_top, in_col_q)),
    .rdata_a_o(rd_mid),
    .rdata_b_o(rd_top)
  );

  // ---------------------------------------------------------------------
  // Compute stage
  assign s1_adv     = s1_valid_q && (!s1_q.produce || !out_valid_q || out_ready_i);
  assign s1_valid_d = in_fire ? take : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Hold the word info alongside the line store read data
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= s1_info;
    end
  end

  // Newest column: two stored rows plus the word itself
  always_comb begin
    col_n.top = rd_top;
    col_n.mid = rd_mid;
    col_n.bot = s1_q.pix;
  end

  // Shift the column window
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      col_a_q <= col_b_q;
      col_b_q <= col_n;
    end
  end

  // Border handling: clamp right, reflect left onto the clamped right
  always_comb begin
    win_c = vfix(col_b_q, s1_q.top_e, s1_q.bot_e);
    win_r = vfix(s1_q.right_e ? col_b_q : col_n, s1_q.top_e, s1_q.bot_e);
    win_l = s1_q.left_e ? win_r : vfix(col_a_q, s1_q.top_e, s1_q.bot_e);
  end

  // Sharpen each channel
  always_comb begin
    logic [10:0] nsum;
    for (int ch = 0; ch < 3; ch++) begin
      nsum = 11'(win_l.top[ch]) + 11'(win_l.mid[ch]) + 11'(win_l.bot[ch]) +
             11'(win_c.top[ch]) + 11'(win_c.bot[ch]) +
             11'(win_r.top[ch]) + 11'(win_r.mid[ch]) + 11'(win_r.bot[ch]);
      res_pix[ch] = sharpen_ch(win_c.mid[ch], nsum, str_q);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_q.produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.produce) begin
      out_pix_q <= res_pix;
      out_fe_q  <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q[2];
  assign green_out_o = out_pix_q[1];
  assign blue_out_o  = out_pix_q[0];
  assign frame_end_o = out_fe_q;

`ifndef NO_ASSERTIONS
  // Input stalls only when both stages are full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // Output column trails the input column by one word within a row
  a_pos_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && produce && out_x_q != last_col |-> in_col_q == out_x_q + 1'b1)
    else $error("output column out of step with input column");

  // Frame end restarts the column, output and prime counters and the done flag
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && frame_end |=> in_col_q == '0 && out_x_q == '0 && out_y_q == 12'd0
                          && !in_done_q && prime_q == 2'd0)
    else $error("counters not cleared after frame end");

  // A stalled compute stage keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("compute stage lost its word");

  // A produced result always reaches the output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.produce |=> out_valid_q)
    else $error("result dropped on the way to the output");
`endif

endmodule

>>> src/rgbshp_ram.sv
// Generic RAM: one write port, two registered read ports.
// Used for the line store of the sharpen block. No dependencies.
module rgbshp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write one word, read two words into the output registers
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> dv/tb_rgb_sharpen_3x3_stream_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_sharpen_3x3_stream_top: directed rows, then random
// frames of many geometries, each word checked against a cycle-free predictor.
// Depends on rgbshp_pkg and the block's RTL.
module tb_rgb_sharpen_3x3_stream_top;
  import rgbshp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned        RandWords = 1500;

  typedef enum logic {KIND_PIXEL = 1'b0, KIND_FLUSH = 1'b1} kind_e;
  typedef enum logic {ROW_REG = 1'b0, ROW_WORD = 1'b1} row_op_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    row_op_e              op;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    kind_e                kind;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    bit                   typed;
    result_t              want;
  } dir_row_t;

  // DUT ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                kind_i      = 1'b0;
  logic [7:0]          red_in_i    = '0;
  logic [7:0]          green_in_i  = '0;
  logic [7:0]          blue_in_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          red_out_o;
  logic [7:0]          green_out_o;
  logic [7:0]          blue_out_o;
  logic                frame_end_o;

  // Predictor state: line store, counters and registers
  logic [23:0]         line_mem [LinesKept*MaxWidthDef];
  int unsigned         in_cnt  = 0;
  int unsigned         out_cnt = 0;
  logic [11:0]         width_reg    = FrameWidthRst;
  logic [11:0]         height_reg   = FrameHeightRst;
  logic [7:0]          strength_reg = StrengthRst;

  // Expected sharpened pixels, oldest first
  result_t             sharpened_q [$];
  result_t             got_want;
  dir_row_t            dir_rows [$];

  // Run control and statistics
  bit                  quiet_in     = 1'b0;
  bit                  quiet_out    = 1'b0;
  int                  hold_req     = 0;
  int                  longest_hold = 0;
  int                  mismatches   = 0;
  int                  words_in     = 0;
  int                  counted      = 0;
  int                  results_seen = 0;
  int                  frames_seen  = 0;
  int                  in_stalls    = 0;
  int                  phases       = 0;

  rgb_sharpen_3x3_stream_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one line per mismatch, cap the noise, always count
  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Reflect -1 to 1, then clamp past the end to the last index
  function automatic int unsigned fold_coord(input int c, input int unsigned n);
    if (c < 0) c = -c;
    if (c >= int'(n)) c = int'(n) - 1;
    return c;
  endfunction

  // Advance the predictor by one word; return 1 when it yields a sharpened pixel
  function automatic bit sharpen_word(input kind_e kind, input logic [23:0] px,
                                      output result_t res);
    int unsigned w, h, total, m, k, yy, xx;
    int          y, x, dy, dx, c, n;
    int          ctr [3];
    int          nsum [3];
    logic [7:0]  ch_out [3];
    logic [23:0] p;
    bit          live, made;
    w     = eff_width();
    h     = eff_height();
    total = w * h;
    m     = in_cnt;
    made  = 1'b0;
    res   = '0;
    // Drop a flush that arrives before the frame is complete
    if (kind == KIND_FLUSH && m < total) return 1'b0;
    live = (m < total);
    if (m >= w + 1) begin
      k = out_cnt;
      y = k / w;
      x = k % w;
      for (c = 0; c < 3; c++) begin
        ctr[c]  = 0;
        nsum[c] = 0;
      end
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          yy = fold_coord(y + dy, h);
          xx = fold_coord(x + dx, w);
          if (live && yy * w + xx == m) begin
            p = px;
          end else begin
            p = line_mem[(yy % LinesKept) * MaxWidthDef + xx];
          end
          for (c = 0; c < 3; c++) begin
            if (dy == 0 && dx == 0) begin
              ctr[c] = p[8*(2-c) +: 8];
            end else begin
              nsum[c] += p[8*(2-c) +: 8];
            end
          end
        end
      end
      for (c = 0; c < 3; c++) begin
        n = 128 * ctr[c] + int'(strength_reg) * (8 * ctr[c] - nsum[c]);
        if (n < 0) begin
          ch_out[c] = 8'd0;
        end else if ((n >>> 7) > 255) begin
          ch_out[c] = 8'd255;
        end else begin
          ch_out[c] = 8'(n >>> 7);
        end
      end
      res.red       = ch_out[0];
      res.green     = ch_out[1];
      res.blue      = ch_out[2];
      res.frame_end = (k + 1 == total);
      made          = 1'b1;
      out_cnt       = k + 1;
    end
    if (live) begin
      line_mem[((m / w) % LinesKept) * MaxWidthDef + (m % w)] = px;
    end
    in_cnt = m + 1;
    if (made && res.frame_end) begin
      in_cnt  = 0;
      out_cnt = 0;
    end
    return made;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_reg(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
    dir_row_t row;
    row      = '0;
    row.op   = ROW_REG;
    row.idx  = idx;
    row.data = data;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_word(input kind_e kind, input logic [7:0] r, g, b,
                                   input bit typed, input logic [7:0] er, eg, eb,
                                   input logic efe);
    dir_row_t row;
    row       = '0;
    row.op    = ROW_WORD;
    row.kind  = kind;
    row.red   = r;
    row.green = g;
    row.blue  = b;
    row.typed = typed;
    row.want  = {er, eg, eb, efe};
    dir_rows.push_back(row);
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input kind_e kind, input logic [7:0] r, g, b,
                           input bit typed, input result_t want);
    int      gap;
    result_t res;
    gap = quiet_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_in++;
    if (sharpen_word(kind, {r, g, b}, res)) begin
      sharpened_q.push_back(typed ? want : res);
    end
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegFrameWidth: begin
        width_reg = data;
        in_cnt    = 0;
        out_cnt   = 0;
      end
      RegFrameHeight: begin
        height_reg = data;
        in_cnt     = 0;
        out_cnt    = 0;
      end
      RegStrength: begin
        strength_reg = data[7:0];
      end
      default: begin
      end
    endcase
  endtask

  // One frame: pixels with stray early flushes, then the drain words (some as
  // late pixels); a limit cuts the frame short
  task automatic send_frame(input int unsigned w, input int unsigned h, input int limit);
    int unsigned total, i;
    int          sent;
    kind_e       kind;
    total = w * h;
    sent  = 0;
    for (i = 0; i < total + w + 1; i++) begin
      if (limit >= 0 && sent >= limit) break;
      if (i < total && $urandom_range(0, 24) == 0) begin
        send_word(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
      end
      kind = (i < total || $urandom_range(0, 4) == 0) ? KIND_PIXEL : KIND_FLUSH;
      send_word(kind, rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
      sent++;
    end
    counted += sent;
    if ($urandom_range(0, 9) == 0) begin
      send_word(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] wreg, hreg, input logic [7:0] sreg,
                           input int frames, input int limit);
    int f;
    settle();
    write_reg(RegFrameWidth, wreg);
    write_reg(RegFrameHeight, hreg);
    write_reg(RegStrength, {4'($urandom_range(0, 15)), sreg});
    for (f = 0; f < frames; f++) begin
      send_frame(eff_width(), eff_height(), (f == frames - 1) ? limit : -1);
    end
    phases++;
  endtask

  // Receiver: random ready gaps, one long hold on request
  initial begin
    int gap;
    forever begin
      if (hold_req > 0) begin
        gap      = hold_req;
        hold_req = 0;
        if (gap > longest_hold) longest_hold = gap;
      end else begin
        gap = quiet_out ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_ready_o) in_stalls++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sharpened_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        got_want = sharpened_q.pop_front();
        if (red_out_o !== got_want.red) begin
          report_mismatch($sformatf("result %0d red %0d, want %0d",
                                    results_seen, red_out_o, got_want.red));
        end
        if (green_out_o !== got_want.green) begin
          report_mismatch($sformatf("result %0d green %0d, want %0d",
                                    results_seen, green_out_o, got_want.green));
        end
        if (blue_out_o !== got_want.blue) begin
          report_mismatch($sformatf("result %0d blue %0d, want %0d",
                                    results_seen, blue_out_o, got_want.blue));
        end
        if (frame_end_o !== got_want.frame_end) begin
          report_mismatch($sformatf("result %0d frame_end %0b, want %0b",
                                    results_seen, frame_end_o, got_want.frame_end));
        end
        if (got_want.frame_end) frames_seen++;
        results_seen++;
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int          i, saved, spin, lim;
    logic [11:0] wreg, hreg;
    logic [7:0]  sreg;

    // At reset geometry an early flush is dropped and a pixel yields nothing
    add_word(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'd12, 8'd34, 8'd56, 1'b0, 0, 0, 0, 1'b0);
    // Zero geometry acts as 1x1, so every tap is the pixel itself; full strength
    add_reg(RegFrameWidth, 12'd0);
    add_reg(RegFrameHeight, 12'd0);
    add_reg(RegStrength, 12'hFFF);
    add_word(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'hFF, 8'h00, 8'hAA, 1'b0, 0, 0, 0, 1'b0);
    // Late pixel acts as a flush
    add_word(KIND_PIXEL, 8'h01, 8'h02, 8'h03, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'h55, 8'h55, 8'h55, 1'b1, 8'hFF, 8'h00, 8'hAA, 1'b1);
    add_word(KIND_PIXEL, 8'h00, 8'hFF, 8'h55, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'hAA, 8'hAA, 8'hAA, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00, 8'hFF, 8'h55, 1'b1);
    // 3x2 at strength zero passes pixels through; the unused index must not land
    add_reg(RegFrameWidth, 12'd3);
    add_reg(RegFrameHeight, 12'd2);
    add_reg(RegStrength, 12'd0);
    add_reg(RegUnused, 12'hFFF);
    add_word(KIND_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'd1,   8'd128, 8'd254, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'd127, 8'd64,  8'd32,  1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'd200, 8'd100, 8'd50,  1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    add_word(KIND_PIXEL, 8'd9,   8'd8,   8'd7,   1'b1, 8'd255, 8'd255, 8'd255, 1'b0);
    add_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, 8'd1,   8'd128, 8'd254, 1'b0);
    add_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, 8'd127, 8'd64,  8'd32,  1'b0);
    add_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, 8'd200, 8'd100, 8'd50,  1'b0);
    add_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, 8'd9,   8'd8,   8'd7,   1'b1);
    // 2x2 checkerboard, mid strength, saturating both ways
    add_reg(RegFrameWidth, 12'd2);
    add_reg(RegFrameHeight, 12'd2);
    add_reg(RegStrength, 12'd128);
    add_word(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0, 1'b0);
    add_word(KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0, 1'b0);

    // Hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].op == ROW_REG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].kind, dir_rows[i].red, dir_rows[i].green,
                  dir_rows[i].blue, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: mostly small frames, plus a back-pressure phase, the
    // widest line and the tallest frame (the last two cut short)
    while (counted < RandWords) begin
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      sreg      = 8'($urandom_range(0, 255));
      if (phases == 3) begin
        quiet_in = 1'b1;
        hold_req = 300;
        run_phase(12'd8, 12'd6, sreg, 2, -1);
      end else if (phases == 5) begin
        saved = counted;
        run_phase(12'hFFF, 12'd2, sreg, 1, MaxWidthDef + 7);
        counted = saved;
      end else if (phases == 8) begin
        saved = counted;
        run_phase(12'd3, 12'hFFF, sreg, 1, 100);
        counted = saved;
      end else begin
        wreg = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
        hreg = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
        case ($urandom_range(0, 5))
          0: sreg = 8'd0;
          1: sreg = 8'd255;
          default: begin
          end
        endcase
        lim = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : -1;
        run_phase(wreg, hreg, sreg, $urandom_range(1, 4), lim);
      end
    end

    // Drain and let the pipeline empty
    in_valid_i <= 1'b0;
    for (spin = 0; spin < 20000 && sharpened_q.size() != 0; spin++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sharpened_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", sharpened_q.size()));
    end

    $display("Run covered %0d input words over %0d random geometry phases; %0d results checked, %0d frames closed.",
             words_in, phases, results_seen, frames_seen);
    $display("Input stalled on %0d cycles; longest output hold %0d cycles; %0d mismatches.",
             in_stalls, longest_hold, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rgbshp_pkg.sv
src/rgbshp_ram.sv
src/rgb_sharpen_3x3_stream_top.sv
dv/tb_rgb_sharpen_3x3_stream_top.sv
